### rtl/wes_pkg.sv
// ----------------------------------------------------------------------------
// wes_pkg
// Shared types and constants of the wave equation stencil step.
// ----------------------------------------------------------------------------
package wes_pkg;

  localparam int GRID_WIDTH_BITS  = 11;
  localparam int GRID_HEIGHT_BITS = 13;
  localparam int CFG_DATA_BITS    = 13;
  localparam int CFG_INDEX_BITS   = 1;
  localparam int MAX_HEIGHT       = 4096;
  localparam int ROW_BITS         = 12;

  localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_HEIGHT = 1'b1;

  localparam logic [GRID_WIDTH_BITS-1:0]  GRID_WIDTH_RESET  = 11'd400;
  localparam logic [GRID_HEIGHT_BITS-1:0] GRID_HEIGHT_RESET = 13'd400;

  // neighbours that fall outside the grid
  typedef struct packed {
    logic zero_above;
    logic zero_below;
    logic zero_left;
    logic zero_right;
  } wes_edge_t;

  // last row index after clamping the height to 2..MAX_HEIGHT
  function automatic logic [ROW_BITS-1:0] height_last(input logic [GRID_HEIGHT_BITS-1:0] gh);
    int v;
    v = int'(gh);
    if (v < 2) v = 2;
    if (v > MAX_HEIGHT) v = MAX_HEIGHT;
    return ROW_BITS'(v - 1);
  endfunction

endpackage

### rtl/wes_in_if.sv
// ----------------------------------------------------------------------------
// wes_in_if
// Input request channel: present and past sample of one raster pixel.
// ----------------------------------------------------------------------------
interface wes_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] present_sample;
  logic signed [SAMPLE_BITS-1:0] past_sample;

  modport source (output valid, output present_sample, output past_sample, input ready);
  modport sink (input valid, input present_sample, input past_sample, output ready);
endinterface

### rtl/wes_out_if.sv
// ----------------------------------------------------------------------------
// wes_out_if
// Result request channel: next-frame sample and end-of-frame flag.
// ----------------------------------------------------------------------------
interface wes_out_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] future_sample;
  logic                          frame_end;

  modport source (output valid, output future_sample, output frame_end, input ready);
  modport sink (input valid, input future_sample, input frame_end, output ready);
endinterface

### rtl/wes_line_store.sv
// ----------------------------------------------------------------------------
// wes_line_store
// Two present-row banks and one past row. The bank being filled gives the
// sample above, the other bank gives left and right. Registered reads.
// ----------------------------------------------------------------------------
module wes_line_store #(
  parameter int MAX_WIDTH   = 1024,
  parameter int SAMPLE_BITS = 16,
  parameter int COL_BITS    = 10
) (
  input  logic                          clk,
  input  logic                          req_en,
  input  logic [COL_BITS-1:0]           col,
  input  logic                          bank,
  input  logic signed [SAMPLE_BITS-1:0] present_sample,
  input  logic signed [SAMPLE_BITS-1:0] past_sample,
  output logic signed [SAMPLE_BITS-1:0] above,
  output logic signed [SAMPLE_BITS-1:0] left,
  output logic signed [SAMPLE_BITS-1:0] right,
  output logic signed [SAMPLE_BITS-1:0] past_row
);

  logic signed [SAMPLE_BITS-1:0] bank0_mem_r [MAX_WIDTH];
  logic signed [SAMPLE_BITS-1:0] bank1_mem_r [MAX_WIDTH];
  logic signed [SAMPLE_BITS-1:0] past_mem_r  [MAX_WIDTH];

  logic signed [SAMPLE_BITS-1:0] b0_rda_r, b0_rdb_r, b1_rda_r, b1_rdb_r, past_rd_r;
  logic                          sel_r;
  logic [COL_BITS-1:0]           col_m1, col_p1;

  assign col_m1 = col - 1'b1;
  assign col_p1 = col + 1'b1;

  always_ff @(posedge clk) begin
    if (req_en) begin
      b0_rda_r <= bank0_mem_r[bank ? col_m1 : col];
      b0_rdb_r <= bank0_mem_r[col_p1];
      if (!bank) begin
        bank0_mem_r[col] <= present_sample;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_en) begin
      b1_rda_r <= bank1_mem_r[bank ? col : col_m1];
      b1_rdb_r <= bank1_mem_r[col_p1];
      if (bank) begin
        bank1_mem_r[col] <= present_sample;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_en) begin
      past_rd_r       <= past_mem_r[col];
      past_mem_r[col] <= past_sample;
      sel_r           <= bank;
    end
  end

  assign above    = sel_r ? b1_rda_r : b0_rda_r;
  assign left     = sel_r ? b0_rda_r : b1_rda_r;
  assign right    = sel_r ? b0_rdb_r : b1_rdb_r;
  assign past_row = past_rd_r;

endmodule

### rtl/wes_stencil.sv
// ----------------------------------------------------------------------------
// wes_stencil
// Five-point update: half the neighbour sum minus the past sample, saturated.
// ----------------------------------------------------------------------------
module wes_stencil #(
  parameter int SAMPLE_BITS = 16
) (
  input  wes_pkg::wes_edge_t            edge_flags,
  input  logic signed [SAMPLE_BITS-1:0] above,
  input  logic signed [SAMPLE_BITS-1:0] below,
  input  logic signed [SAMPLE_BITS-1:0] left,
  input  logic signed [SAMPLE_BITS-1:0] right,
  input  logic signed [SAMPLE_BITS-1:0] past_row,
  output logic signed [SAMPLE_BITS-1:0] future_sample
);

  localparam int SB = SAMPLE_BITS;

  logic signed [SB+1:0] a_x, b_x, l_x, r_x, p_x, sum_w, diff_w;
  logic signed [SB:0]   half_w;

  assign a_x = edge_flags.zero_above ? '0 : {{2{above[SB-1]}}, above};
  assign b_x = edge_flags.zero_below ? '0 : {{2{below[SB-1]}}, below};
  assign l_x = edge_flags.zero_left  ? '0 : {{2{left[SB-1]}}, left};
  assign r_x = edge_flags.zero_right ? '0 : {{2{right[SB-1]}}, right};
  assign p_x = {{2{past_row[SB-1]}}, past_row};

  assign sum_w  = a_x + b_x + l_x + r_x;
  // floor halving
  assign half_w = sum_w[SB+1:1];
  assign diff_w = {half_w[SB], half_w} - p_x;

  always_comb begin
    if (diff_w[SB+1:SB-1] == 3'b000 || diff_w[SB+1:SB-1] == 3'b111) begin
      future_sample = diff_w[SB-1:0];
    end else if (diff_w[SB+1]) begin
      future_sample = {1'b1, {(SB-1){1'b0}}};
    end else begin
      future_sample = {1'b0, {(SB-1){1'b1}}};
    end
  end

endmodule

### rtl/wave_equation_stencil_step.sv
// ----------------------------------------------------------------------------
// wave_equation_stencil_step
// 2D wave equation leapfrog step over a raster stream of grid samples.
// Path: read stage, then result register; the result is for the pixel one row
//   behind (first row after reset or a grid write: no result).
// Throughput: 1 request per cycle unless stalled; two reads, one write per bank.
// Reset: position and frame state cleared, grid size set to 400 x 400; line
//   stores keep no reset state, no clearing pass.
// ----------------------------------------------------------------------------
module wave_equation_stencil_step #(
  parameter int MAX_WIDTH   = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  wes_in_if.sink                               in_req,
  wes_out_if.source                            out_req,
  input  logic                                 cfg_we,
  input  logic [wes_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [wes_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  localparam int COL_BITS = $clog2(MAX_WIDTH);

  function automatic logic [COL_BITS-1:0] width_last(
    input logic [wes_pkg::GRID_WIDTH_BITS-1:0] gw);
    int v;
    v = int'(gw);
    if (v < 2) v = 2;
    if (v > MAX_WIDTH) v = MAX_WIDTH;
    return COL_BITS'(v - 1);
  endfunction

  logic [COL_BITS-1:0]           wlast_r, col_r;
  logic [wes_pkg::ROW_BITS-1:0]  hlast_r, row_r;
  logic                          bank_r, pend_r;
  logic                          s1_v_r, s1_end_r;
  wes_pkg::wes_edge_t            s1_edge_r, edge_nxt;
  logic signed [SAMPLE_BITS-1:0] s1_below_r;
  logic                          out_v_r, out_end_r;
  logic signed [SAMPLE_BITS-1:0] out_sample_r;

  logic                          in_acc, adv_out, has_res, col_end;
  logic signed [SAMPLE_BITS-1:0] above, left, right, past_row, future;

  assign adv_out      = !out_v_r || out_req.ready;
  assign in_req.ready = !s1_v_r || adv_out;
  assign in_acc       = in_req.valid && in_req.ready;
  assign has_res      = (row_r != '0) || pend_r;
  assign col_end      = (col_r == wlast_r);

  assign edge_nxt.zero_above = (row_r == wes_pkg::ROW_BITS'(1));
  assign edge_nxt.zero_below = (row_r == '0);
  assign edge_nxt.zero_left  = (col_r == '0);
  assign edge_nxt.zero_right = col_end;

  // grid size and raster position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlast_r <= width_last(wes_pkg::GRID_WIDTH_RESET);
      hlast_r <= wes_pkg::height_last(wes_pkg::GRID_HEIGHT_RESET);
      col_r   <= '0;
      row_r   <= '0;
      bank_r  <= 1'b0;
      pend_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        wes_pkg::REG_GRID_WIDTH: begin
          wlast_r <= width_last(cfg_data[wes_pkg::GRID_WIDTH_BITS-1:0]);
        end
        wes_pkg::REG_GRID_HEIGHT: begin
          hlast_r <= wes_pkg::height_last(cfg_data);
        end
        default: begin
        end
      endcase
      col_r  <= '0;
      row_r  <= '0;
      pend_r <= 1'b0;
    end else if (in_acc) begin
      if (col_end) begin
        col_r  <= '0;
        bank_r <= !bank_r;
        if (row_r == hlast_r) begin
          row_r  <= '0;
          pend_r <= 1'b1;
        end else begin
          row_r <= row_r + 1'b1;
        end
      end else begin
        col_r <= col_r + 1'b1;
      end
    end
  end

  // read stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_acc) begin
      s1_v_r <= has_res;
    end else if (adv_out) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_edge_r  <= edge_nxt;
      s1_end_r   <= (row_r == '0) && col_end;
      s1_below_r <= in_req.present_sample;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv_out) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out && s1_v_r) begin
      out_sample_r <= future;
      out_end_r    <= s1_end_r;
    end
  end

  assign out_req.valid         = out_v_r;
  assign out_req.future_sample = out_sample_r;
  assign out_req.frame_end     = out_end_r;

  wes_line_store #(
    .MAX_WIDTH   (MAX_WIDTH),
    .SAMPLE_BITS (SAMPLE_BITS),
    .COL_BITS    (COL_BITS)
  ) u_line_store (
    .clk            (clk),
    .req_en         (in_acc),
    .col            (col_r),
    .bank           (bank_r),
    .present_sample (in_req.present_sample),
    .past_sample    (in_req.past_sample),
    .above          (above),
    .left           (left),
    .right          (right),
    .past_row       (past_row)
  );

  wes_stencil #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_stencil (
    .edge_flags    (s1_edge_r),
    .above         (above),
    .below         (s1_below_r),
    .left          (left),
    .right         (right),
    .past_row      (past_row),
    .future_sample (future)
  );

  a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= wlast_r)
    else $error("column beyond grid width");

  a_row_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !cfg_we && (row_r != '0) |=> s1_v_r)
    else $error("request below first row produced no result");

  a_pend_on_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(pend_r) |-> $past(in_acc && col_r == wlast_r && row_r == hlast_r))
    else $error("frame pending set without frame wrap");

endmodule
